// ===== rtl/tte_pkg.sv =====
// Shared types, constants and the tone table generator for the tape tone-burst encoder.
// No dependencies.
package tte_pkg;

  localparam int MAX_PIP_LEN   = 512;
  localparam int POS_W         = $clog2(MAX_PIP_LEN);
  localparam int LEN_W         = 10;
  localparam int LEFT_W        = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 10;

  localparam logic [LEFT_W-1:0] PREAMBLE_PIPS = LEFT_W'(120);
  localparam logic [LEFT_W-1:0] GAP_PIPS      = LEFT_W'(64);
  localparam logic [LEN_W-1:0]  PIP_LEN_RST   = LEN_W'(352);

  // request codes
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_LOAD  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIP_LEN  = 2'd2;

  // tone generation constants (angles in fixed point Q60)
  localparam logic [63:0] TONE_AMP    = 64'd32000;
  localparam logic [63:0] TONE_FREQ   = 64'd1000;
  localparam logic [63:0] TONE_FS     = 64'd11025;
  localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611B;
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
  // angle per unit of m, split into whole part and remainder for an exact floor
  localparam logic [63:0] TONE_STEP   = TWO_PI_Q60 / TONE_FS;
  localparam logic [63:0] TONE_REM    = TWO_PI_Q60 % TONE_FS;

  typedef logic signed [15:0] tone_rom_t [MAX_PIP_LEN];

  // per-item results handed from the control logic to the output stages
  typedef struct packed {
    logic sample_valid;
    logic holding_empty;
    logic frame_active;
    logic request_rejected;
    logic tone_on;
  } tte_stage_t;

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Taylor term n divides by (2n)*(2n+1)
  function automatic logic [63:0] taylor_div(input int n, input logic [63:0] v);
    logic [63:0] q;
    case (n)
      1:       q = v / 64'd6;
      2:       q = v / 64'd20;
      3:       q = v / 64'd42;
      4:       q = v / 64'd72;
      5:       q = v / 64'd110;
      6:       q = v / 64'd156;
      7:       q = v / 64'd210;
      8:       q = v / 64'd272;
      9:       q = v / 64'd342;
      10:      q = v / 64'd420;
      11:      q = v / 64'd506;
      default: q = v / 64'd600;
    endcase
    return q;
  endfunction

  // elaboration only: truncated Taylor sine scaled to the tone amplitude
  function automatic logic signed [15:0] tone_value(input int unsigned k);
    logic [63:0]        m;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    logic               neg;
    m   = ((64'(k) + 64'd1) * TONE_FREQ) % TONE_FS;
    neg = 1'b0;
    if (m * 64'd2 > TONE_FS) begin
      m   = TONE_FS - m;
      neg = 1'b1;
    end
    x    = TONE_STEP * m + (TONE_REM * m) / TONE_FS;
    if (x > PI_Q60) x = PI_Q60;
    if (x > HALF_PI_Q60) x = PI_Q60 - x;
    x2   = mul_q60(x, x);
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 12; n++) begin
      term = taylor_div(n, mul_q60(term, x2));
      if ((n % 2) == 1) sum = sum - signed'(term);
      else              sum = sum + signed'(term);
    end
    if (sum < 0) sum = '0;
    v = mul_q60(unsigned'(sum), TONE_AMP);
    if (v > TONE_AMP) v = TONE_AMP;
    return neg ? -signed'(v[15:0]) : signed'(v[15:0]);
  endfunction

  function automatic tone_rom_t build_tone_rom();
    tone_rom_t rom;
    for (int k = 0; k < MAX_PIP_LEN; k++) begin
      rom[k] = tone_value(k);
    end
    return rom;
  endfunction

endpackage

// ===== rtl/tape_tone_burst_bit_encoder_core.sv =====
// Tape tone-burst bit encoder top level: request pipeline and output register.
// Depends on tte_pkg, tte_ctrl and tte_tone_rom.
//
// Takes one request per clock with in_stall low (start frame, load byte, sample
// tick) and returns exactly one result per request, in order. A frame is an
// optional leader of 120 full-tone pips, a 64-pip silent gap unless inverted, then
// the queued bytes LSB first, one pip per bit; it closes at a byte boundary with no
// byte held. Sustained rate is one request per cycle with out_stall low; a result
// passes the stage register and the registered tone ROM read, then the output
// register. out_stall holds the output register and, once the stage behind it is
// full, backs up to in_stall. The tone table is a constant ROM, so no clearing pass
// follows reset. Configuration may change only while no request is in flight.
module tape_tone_burst_bit_encoder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [7:0]                     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             out_sample_value,
  output logic                           out_sample_valid,
  output logic                           out_holding_empty,
  output logic                           out_frame_active,
  output logic                           out_request_rejected
);
  import tte_pkg::*;

  tte_stage_t         stage_nxt;
  tte_stage_t         stage_r;
  logic               stage_vld_r, stage_vld_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [POS_W-1:0]   rom_addr;
  logic signed [15:0] rom_data;
  logic               accept;
  logic               out_ready;
  logic               stage_move;

  assign out_ready  = !out_vld_r || !out_stall;
  assign stage_move = stage_vld_r && out_ready;
  assign in_stall   = stage_vld_r && !out_ready;
  assign accept     = in_valid && !in_stall;

  assign stage_vld_nxt = accept || (stage_vld_r && !stage_move);
  assign out_vld_nxt   = stage_move || (out_vld_r && out_stall);
  assign out_valid     = out_vld_r;

  tte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .req_type  (in_req_type),
    .data_byte (in_data_byte),
    .stage_nxt (stage_nxt),
    .rom_addr  (rom_addr)
  );

  tte_tone_rom u_rom (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
    if (stage_move) begin
      out_sample_value     <= stage_r.tone_on ? rom_data : 16'sd0;
      out_sample_valid     <= stage_r.sample_valid;
      out_holding_empty    <= stage_r.holding_empty;
      out_frame_active     <= stage_r.frame_active;
      out_request_rejected <= stage_r.request_rejected;
    end
  end

endmodule

// ===== rtl/tte_tone_rom.sv =====
// Synchronous tone ROM with a registered read.
// Depends on tte_pkg for the table builder.
module tte_tone_rom (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [tte_pkg::POS_W-1:0] rd_addr,
  output logic signed [15:0]        rd_data
);
  import tte_pkg::*;

  localparam tone_rom_t ToneRom = build_tone_rom();

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ToneRom[rd_addr];
    end
  end

endmodule

// ===== rtl/tte_ctrl.sv =====
// Frame sequencer: configuration registers, pip/bit/leader and gap counters, holding and shift bytes.
// Depends on tte_pkg; drives the tone ROM address and the per-item stage results.
module tte_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           accept,
  input  logic [1:0]                     req_type,
  input  logic [7:0]                     data_byte,
  output tte_pkg::tte_stage_t            stage_nxt,
  output logic [tte_pkg::POS_W-1:0]      rom_addr
);
  import tte_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_GAP, PH_DATA} phase_t;

  logic             invert_r;
  logic             preamble_r;
  logic [LEN_W-1:0] pip_len_r;

  phase_t            phase_r, phase_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [2:0]        bit_idx_r, bit_idx_nxt;
  logic [LEFT_W-1:0] left_r, left_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic              hold_full_r, hold_full_nxt;

  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  thr;
  logic [LEN_W-1:0]  pos_ext;
  logic              wrap;
  logic              on_data;
  logic              boundary;
  logic              rejected;
  logic              valid;
  logic              tone_on;

  assign rom_addr = pos_r;

  always_comb begin
    if (pip_len_r == '0) begin
      len = LEN_W'(1);
    end else if (pip_len_r > LEN_W'(MAX_PIP_LEN)) begin
      len = LEN_W'(MAX_PIP_LEN);
    end else begin
      len = pip_len_r;
    end
    thr     = shift_r[bit_idx_r] ? (len >> 1) : (len >> 3);
    pos_ext = {1'b0, pos_r};
    on_data = invert_r ? (pos_ext > thr) : (pos_ext < thr);
    wrap    = (pos_ext + LEN_W'(1)) >= len;
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    bit_idx_nxt   = bit_idx_r;
    left_nxt      = left_r;
    shift_nxt     = shift_r;
    hold_nxt      = hold_r;
    hold_full_nxt = hold_full_r;
    boundary      = 1'b0;
    rejected      = 1'b0;
    valid         = 1'b0;
    tone_on       = 1'b0;
    case (req_type)
      REQ_START: begin
        if (phase_r != PH_IDLE) begin
          rejected = 1'b1;
        end else begin
          pos_nxt     = '0;
          bit_idx_nxt = '0;
          if (preamble_r) begin
            phase_nxt = PH_LEAD;
            left_nxt  = PREAMBLE_PIPS;
          end else if (!invert_r) begin
            phase_nxt = PH_GAP;
            left_nxt  = GAP_PIPS;
          end else begin
            boundary = 1'b1;
          end
        end
      end
      REQ_LOAD: begin
        if (hold_full_r) begin
          rejected = 1'b1;
        end else begin
          hold_nxt      = data_byte;
          hold_full_nxt = 1'b1;
        end
      end
      REQ_TICK: begin
        valid = 1'b1;
        if (phase_r != PH_IDLE) begin
          tone_on = (phase_r == PH_LEAD) || ((phase_r == PH_DATA) && on_data);
          if (wrap) begin
            pos_nxt = '0;
            if (phase_r == PH_LEAD) begin
              left_nxt = left_r - LEFT_W'(1);
              if (left_nxt == '0) begin
                if (!invert_r) begin
                  phase_nxt = PH_GAP;
                  left_nxt  = GAP_PIPS;
                end else begin
                  boundary = 1'b1;
                end
              end
            end else if (phase_r == PH_GAP) begin
              left_nxt = left_r - LEFT_W'(1);
              if (left_nxt == '0) boundary = 1'b1;
            end else begin
              bit_idx_nxt = bit_idx_r + 3'd1;
              if (bit_idx_nxt == '0) boundary = 1'b1;
            end
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    // byte boundary: reload the shifter or close the frame
    if (boundary) begin
      pos_nxt     = '0;
      bit_idx_nxt = '0;
      if (hold_full_r) begin
        shift_nxt     = hold_r;
        hold_full_nxt = 1'b0;
        phase_nxt     = PH_DATA;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
    stage_nxt.sample_valid     = valid;
    stage_nxt.holding_empty    = !hold_full_nxt;
    stage_nxt.frame_active     = (phase_nxt != PH_IDLE);
    stage_nxt.request_rejected = rejected;
    stage_nxt.tone_on          = tone_on;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r    <= 1'b0;
      preamble_r  <= 1'b0;
      pip_len_r   <= PIP_LEN_RST;
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      bit_idx_r   <= '0;
      left_r      <= '0;
      shift_r     <= '0;
      hold_full_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INVERT:   invert_r   <= cfg_wdata[0];
          CFG_PREAMBLE: preamble_r <= cfg_wdata[0];
          CFG_PIP_LEN:  pip_len_r  <= cfg_wdata[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        pos_r       <= pos_nxt;
        bit_idx_r   <= bit_idx_nxt;
        left_r      <= left_nxt;
        shift_r     <= shift_nxt;
        hold_full_r <= hold_full_nxt;
      end
    end
  end

  // holding byte is only read while marked full
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

// ===== test/tte_result_checker.sv =====
// Result checker for the tape tone-burst encoder: tracks the frame state from the
// accepted requests and configuration writes and compares every result transfer.
// Depends on tte_pkg for the request and register codes.
module tte_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [7:0]                     in_data_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [15:0]             out_sample_value,
  input  logic                           out_sample_valid,
  input  logic                           out_holding_empty,
  input  logic                           out_frame_active,
  input  logic                           out_request_rejected,
  output int                             mismatch_count,
  output int                             results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import tte_pkg::*;

  localparam logic [63:0] PI_FX      = 64'h3243F6A8885A308D;
  localparam logic [63:0] TWO_PI_FX  = 64'h6487ED5110B4611B;
  localparam logic [63:0] HALF_PI_FX = 64'h1921FB54442D1846;
  localparam logic [63:0] RATE_HZ    = 64'd11025;
  localparam logic [63:0] AMPLITUDE  = 64'd32000;

  typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_GAP, PH_DATA} frame_phase_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               tick;
    logic               empty;
    logic               active;
    logic               rejected;
  } encoder_result_t;

  logic signed [15:0] tone_table [MAX_PIP_LEN];
  encoder_result_t    expected_results [$];

  // configuration copy
  logic               cfg_inv;
  logic               cfg_pre;
  logic [LEN_W-1:0]   cfg_len;

  // frame state
  frame_phase_t       frame_phase;
  int unsigned        pip_pos;
  logic [2:0]         bit_idx;
  logic [LEFT_W-1:0]  pips_left;
  logic [7:0]         shifter;
  logic [7:0]         held;
  logic               held_full;

  // floor(a*b / 2^60)
  function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // sin(2*pi*1000*(k+1)/11025)*32000, Taylor series in unsigned Q60
  function automatic logic signed [15:0] sine_sample(input int k);
    logic [63:0]        ph;
    logic [63:0]        ang;
    logic [63:0]        sq;
    logic [63:0]        t;
    logic [63:0]        mag;
    logic signed [63:0] acc;
    logic               flip;
    ph   = ((64'(k) + 64'd1) * 64'd1000) % RATE_HZ;
    flip = (ph * 64'd2) > RATE_HZ;
    if (flip) ph = RATE_HZ - ph;
    ang = (TWO_PI_FX / RATE_HZ) * ph + ((TWO_PI_FX % RATE_HZ) * ph) / RATE_HZ;
    if (ang > PI_FX) ang = PI_FX;
    if (ang > HALF_PI_FX) ang = PI_FX - ang;
    sq  = q60_product(ang, ang);
    t   = ang;
    acc = $signed(ang);
    for (int n = 1; n <= 12; n++) begin
      t = q60_product(t, sq) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) acc = acc - $signed(t);
      else              acc = acc + $signed(t);
    end
    if (acc < 0) acc = '0;
    mag = q60_product(acc, AMPLITUDE);
    if (mag > AMPLITUDE) mag = AMPLITUDE;
    return flip ? -$signed(mag[15:0]) : $signed(mag[15:0]);
  endfunction

  // byte boundary: pull the held byte into the shifter or close the frame
  function automatic void close_byte();
    pip_pos = 0;
    bit_idx = '0;
    if (held_full) begin
      shifter     = held;
      held_full   = 1'b0;
      frame_phase = PH_DATA;
    end else begin
      frame_phase = PH_IDLE;
    end
  endfunction

  function automatic encoder_result_t encode_request(input logic [1:0] req,
                                                     input logic [7:0] data_in);
    encoder_result_t r;
    int unsigned     len;
    int unsigned     thr;
    logic            tone_on;
    r = '0;
    case (req)
      REQ_START: begin
        if (frame_phase != PH_IDLE) begin
          r.rejected = 1'b1;
        end else begin
          pip_pos = 0;
          bit_idx = '0;
          if (cfg_pre) begin
            frame_phase = PH_LEAD;
            pips_left   = PREAMBLE_PIPS;
          end else if (!cfg_inv) begin
            frame_phase = PH_GAP;
            pips_left   = GAP_PIPS;
          end else begin
            close_byte();
          end
        end
      end
      REQ_LOAD: begin
        if (held_full) begin
          r.rejected = 1'b1;
        end else begin
          held      = data_in;
          held_full = 1'b1;
        end
      end
      REQ_TICK: begin
        r.tick = 1'b1;
        if (frame_phase != PH_IDLE) begin
          if (cfg_len == 0) len = 1;
          else if (cfg_len > MAX_PIP_LEN) len = MAX_PIP_LEN;
          else len = cfg_len;
          if (frame_phase == PH_LEAD) begin
            r.sample = tone_table[pip_pos];
          end else if (frame_phase == PH_DATA) begin
            thr     = shifter[bit_idx] ? len / 2 : len / 8;
            tone_on = cfg_inv ? (pip_pos > thr) : (pip_pos < thr);
            if (tone_on) r.sample = tone_table[pip_pos];
          end
          // a shrunk length ends the pip at once
          if (pip_pos + 1 >= len) begin
            pip_pos = 0;
            case (frame_phase)
              PH_LEAD: begin
                pips_left = pips_left - 1'b1;
                if (pips_left == 0) begin
                  if (!cfg_inv) begin
                    frame_phase = PH_GAP;
                    pips_left   = GAP_PIPS;
                  end else begin
                    close_byte();
                  end
                end
              end
              PH_GAP: begin
                pips_left = pips_left - 1'b1;
                if (pips_left == 0) close_byte();
              end
              default: begin
                bit_idx = bit_idx + 1'b1;
                if (bit_idx == 0) close_byte();
              end
            endcase
          end else begin
            pip_pos = pip_pos + 1;
          end
        end
      end
      default: ;
    endcase
    r.empty  = !held_full;
    r.active = (frame_phase != PH_IDLE);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    for (int k = 0; k < MAX_PIP_LEN; k++) tone_table[k] = sine_sample(k);
  end

  always @(posedge clk) begin
    encoder_result_t want;
    if (!rst_n) begin
      cfg_inv     = 1'b0;
      cfg_pre     = 1'b0;
      cfg_len     = PIP_LEN_RST;
      frame_phase = PH_IDLE;
      pip_pos     = 0;
      bit_idx     = '0;
      pips_left   = '0;
      shifter     = '0;
      held        = '0;
      held_full   = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INVERT:   cfg_inv = cfg_wdata[0];
          CFG_PREAMBLE: cfg_pre = cfg_wdata[0];
          CFG_PIP_LEN:  cfg_len = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_results.push_back(encode_request(in_req_type, in_data_byte));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_sample_value !== want.sample)
            report_mismatch("sample_value", out_sample_value, want.sample);
          if (out_sample_valid !== want.tick)
            report_mismatch("sample_valid", out_sample_valid, want.tick);
          if (out_holding_empty !== want.empty)
            report_mismatch("holding_empty", out_holding_empty, want.empty);
          if (out_frame_active !== want.active)
            report_mismatch("frame_active", out_frame_active, want.active);
          if (out_request_rejected !== want.rejected)
            report_mismatch("request_rejected", out_request_rejected, want.rejected);
        end
      end
    end
    results_due <= expected_results.size();
  end

endmodule

// ===== test/tape_tone_burst_bit_encoder_core_test.sv =====
// Top of the tape tone-burst encoder test: clock, reset, request and config stimulus,
// random stalls and the verdict. Depends on tte_pkg, the core and tte_result_checker.
module tape_tone_burst_bit_encoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tte_pkg::*;

  localparam logic [1:0]           REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
  localparam int                   ITEM_GOAL  = 1850;
  localparam int                   IDLE_LIMIT = 1000;
  localparam int                   HOLD_LEN   = 60;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_req_type = REQ_TICK;
  logic [7:0]            in_data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic signed [15:0]    out_sample_value;
  logic                  out_sample_valid;
  logic                  out_holding_empty;
  logic                  out_frame_active;
  logic                  out_request_rejected;

  int                    mismatch_count;
  int                    results_due;
  int                    idle_cycles = 0;
  bit                    quiet = 1'b0;
  bit                    hold_asked = 1'b0;

  tape_tone_burst_bit_encoder_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sample_value     (out_sample_value),
    .out_sample_valid     (out_sample_valid),
    .out_holding_empty    (out_holding_empty),
    .out_frame_active     (out_frame_active),
    .out_request_rejected (out_request_rejected)
  );

  tte_result_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_data_byte         (in_data_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sample_value     (out_sample_value),
    .out_sample_valid     (out_sample_valid),
    .out_holding_empty    (out_holding_empty),
    .out_frame_active     (out_frame_active),
    .out_request_rejected (out_request_rejected),
    .mismatch_count       (mismatch_count),
    .results_due          (results_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin
    bit hold_served;
    hold_served = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked && !hold_served) begin
        hold_served = 1'b1;
        for (int c = 0; c < HOLD_LEN; c++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end else begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 27);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("tape_tone_burst_bit_encoder_core test failed");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge with the register written
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_request(input logic [1:0] req, input logic [7:0] data);
    while (!quiet && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    int               sent;
    int               phase_no;
    int               count;
    int               load_pct;
    int               r;
    logic [LEN_W-1:0] len_sel;
    logic             inv_sel;
    logic             pre_sel;

    sent     = 0;
    phase_no = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle tick, unused code, load overflow, start while active
    send_request(REQ_TICK, 8'h00);
    send_request(REQ_UNUSED, 8'hFF);
    send_request(REQ_LOAD, 8'h00);
    send_request(REQ_LOAD, 8'hFF);
    send_request(REQ_START, 8'h00);
    send_request(REQ_START, 8'hFF);
    send_request(REQ_TICK, 8'h00);
    send_request(REQ_TICK, 8'h00);
    drain_results();
    // zero length clamps to one sample per pip
    write_reg(CFG_PIP_LEN, '0);
    write_reg(CFG_INVERT, 10'd1);
    write_reg(CFG_PREAMBLE, 10'd0);
    repeat (6) send_request(REQ_TICK, 8'h00);
    drain_results();
    // oversize length clamps to the table size; spare index is ignored
    write_reg(CFG_INVERT, 10'd0);
    write_reg(CFG_PREAMBLE, 10'd1);
    write_reg(CFG_PIP_LEN, 10'h3FF);
    write_reg(CFG_SPARE, 10'h3FF);
    repeat (4) send_request(REQ_TICK, 8'h00);
    send_request(REQ_LOAD, 8'h80);
    send_request(REQ_TICK, 8'h00);
    drain_results();

    while (sent < ITEM_GOAL) begin
      quiet = (phase_no == 6);
      if (phase_no == 3) hold_asked = 1'b1;
      r = $urandom_range(0, 9);
      if (r == 0) begin
        len_sel = LEN_W'($urandom_range(0, 3));
      end else if (r == 1) begin
        case ($urandom_range(0, 4))
          0:       len_sel = 10'd512;
          1:       len_sel = 10'd1023;
          2:       len_sel = 10'd513;
          3:       len_sel = 10'd390;
          default: len_sel = 10'd352;
        endcase
      end else begin
        len_sel = LEN_W'($urandom_range(4, 24));
      end
      inv_sel = 1'($urandom_range(0, 1));
      // a leader only at tiny pips, else it eats the whole run
      pre_sel = (len_sel <= 3) ? ($urandom_range(0, 2) == 0) : 1'b0;
      write_reg(CFG_INVERT, CFG_DATA_W'(inv_sel));
      write_reg(CFG_PREAMBLE, CFG_DATA_W'(pre_sel));
      write_reg(CFG_PIP_LEN, len_sel);

      load_pct = $urandom_range(1, 15);
      count    = quiet ? 150 : $urandom_range(40, 90);
      repeat (count) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          send_request(REQ_START, 8'($urandom_range(0, 255)));
          sent++;
        end else if (r < 6 + load_pct) begin
          send_request(REQ_LOAD, 8'($urandom_range(0, 255)));
          sent++;
        end else if (r < 9 + load_pct) begin
          send_request(REQ_UNUSED, 8'($urandom_range(0, 255)));
        end else begin
          send_request(REQ_TICK, 8'($urandom_range(0, 255)));
          sent++;
        end
      end
      drain_results();
      phase_no++;
    end

    quiet = 1'b0;
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("tape_tone_burst_bit_encoder_core test passed");
    end else begin
      $display("tape_tone_burst_bit_encoder_core test failed");
    end
    $finish;
  end

endmodule
